[hw/rtl/indexed_deque_store_macros.svh]
// assertion macros for the indexed deque store
`ifndef INDEXED_DEQUE_STORE_MACROS_SVH
`define INDEXED_DEQUE_STORE_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define IDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// condition must never be seen outside reset
`define IDS_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define IDS_ASSERT(lbl, clk, rstn, prop)
`define IDS_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[hw/rtl/ids_pkg.sv]
`default_nettype none

package ids_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT_AT  = 3'd4,
    CMD_DELETE_AT  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [31:0]       item_value;
    logic [5:0]               position;
  } ids_in_t;

  typedef struct packed {
    logic signed [31:0]       taken_value;
    status_e                  status;
    logic [6:0]               length;
  } ids_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_TAKE,
    S_SHIFT,
    S_FINISH,
    S_RESP
  } ctrl_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_PLAN,
    OP_READ,
    OP_TAKE,
    OP_SHIFT,
    OP_FINISH,
    OP_OUTPUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ids_cmd_t;

  typedef struct packed {
    logic fail;
    logic is_remove;
    logic has_copies;
    logic shift_busy;
  } ids_stat_t;

endpackage

`default_nettype wire

[hw/rtl/ids_datapath.sv]
`default_nettype none

module ids_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ids_pkg::ids_cmd_t cmd_i,
  input  wire ids_pkg::ids_in_t  in_word_i,
  output ids_pkg::ids_stat_t     stat_o,
  output ids_pkg::ids_out_t      out_word_o
);

  logic [ids_pkg::VALUE_WIDTH-1:0] mem [ids_pkg::CAPACITY];

  ids_pkg::ids_in_t                item_q;
  logic [ids_pkg::IDX_W-1:0]       front_q;
  logic [ids_pkg::CNT_W-1:0]       count_q;
  ids_pkg::status_e                status_q;
  logic [ids_pkg::IDX_W-1:0]       p_q;
  logic [ids_pkg::IDX_W-1:0]       src_q;
  logic [ids_pkg::IDX_W-1:0]       dst_q;
  logic [ids_pkg::CNT_W-1:0]       left_q;
  logic                            inflight_q;
  logic                            down_q;
  logic [ids_pkg::VALUE_WIDTH-1:0] taken_q;
  logic [ids_pkg::VALUE_WIDTH-1:0] rd_data_q;
  ids_pkg::ids_out_t               out_q;

  logic                            is_ins;
  logic                            is_rem;
  ids_pkg::status_e                plan_status;
  logic [ids_pkg::IDX_W-1:0]       plan_p;
  logic [ids_pkg::CNT_W-1:0]       plan_n;
  logic [ids_pkg::CNT_W-1:0]       pos_ext;

  logic                            rd_en;
  logic [ids_pkg::IDX_W-1:0]       rd_addr;
  logic                            wr_en;
  logic [ids_pkg::IDX_W-1:0]       wr_addr;
  logic [ids_pkg::VALUE_WIDTH-1:0] wr_data;

  // command decode and planning from the latched word
  always_comb begin
    is_ins = (item_q.cmd == ids_pkg::CMD_PUSH_BACK) || (item_q.cmd == ids_pkg::CMD_PUSH_FRONT) ||
             (item_q.cmd == ids_pkg::CMD_INSERT_AT);
    is_rem = (item_q.cmd == ids_pkg::CMD_POP_BACK) || (item_q.cmd == ids_pkg::CMD_POP_FRONT) ||
             (item_q.cmd == ids_pkg::CMD_DELETE_AT);
    pos_ext     = ids_pkg::CNT_W'(item_q.position);
    plan_status = ids_pkg::STAT_OK;
    plan_p      = '0;
    plan_n      = '0;
    if (is_ins) begin
      if (count_q == ids_pkg::CNT_W'(ids_pkg::CAPACITY)) begin
        plan_status = ids_pkg::STAT_FULL;
      end else if (item_q.cmd == ids_pkg::CMD_PUSH_BACK) begin
        plan_p = count_q[ids_pkg::IDX_W-1:0];
      end else if ((item_q.cmd == ids_pkg::CMD_PUSH_FRONT) || (count_q == '0)) begin
        plan_p = '0;
      end else if (pos_ext >= count_q) begin
        plan_status = ids_pkg::STAT_RANGE;
      end else begin
        plan_p = item_q.position[ids_pkg::IDX_W-1:0];
      end
      if (plan_p != '0) begin
        plan_n = count_q - ids_pkg::CNT_W'(plan_p);
      end
    end else if (is_rem) begin
      if (count_q == '0) begin
        plan_status = ids_pkg::STAT_EMPTY;
      end else if (item_q.cmd == ids_pkg::CMD_POP_BACK) begin
        plan_p = ids_pkg::IDX_W'(count_q - ids_pkg::CNT_W'(1));
      end else if (item_q.cmd == ids_pkg::CMD_POP_FRONT) begin
        plan_p = '0;
      end else if (pos_ext >= count_q) begin
        plan_status = ids_pkg::STAT_RANGE;
      end else begin
        plan_p = item_q.position[ids_pkg::IDX_W-1:0];
      end
      if ((plan_p != '0) && (count_q != '0)) begin
        plan_n = count_q - ids_pkg::CNT_W'(1) - ids_pkg::CNT_W'(plan_p);
      end
    end
  end

  assign stat_o.fail       = (!is_ins && !is_rem) || (plan_status != ids_pkg::STAT_OK);
  assign stat_o.is_remove  = is_rem;
  assign stat_o.has_copies = (plan_n != '0);
  assign stat_o.shift_busy = (left_q != '0) || inflight_q;

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = front_q + p_q;
    wr_en   = 1'b0;
    wr_addr = front_q + dst_q;
    wr_data = rd_data_q;
    unique case (cmd_i.op)
      ids_pkg::OP_READ: begin
        rd_en = 1'b1;
      end
      ids_pkg::OP_SHIFT: begin
        rd_en   = (left_q != '0);
        rd_addr = front_q + src_q;
        wr_en   = inflight_q;
      end
      ids_pkg::OP_FINISH: begin
        wr_en   = is_ins;
        wr_addr = (p_q == '0) ? (front_q - ids_pkg::IDX_W'(1)) : (front_q + p_q);
        wr_data = ids_pkg::VALUE_WIDTH'(item_q.item_value);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q    <= '0;
      count_q    <= '0;
      left_q     <= '0;
      inflight_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        ids_pkg::OP_PLAN: begin
          left_q     <= plan_n;
          inflight_q <= 1'b0;
        end
        ids_pkg::OP_SHIFT: begin
          if (left_q != '0) begin
            left_q <= left_q - ids_pkg::CNT_W'(1);
          end
          inflight_q <= (left_q != '0);
        end
        ids_pkg::OP_FINISH: begin
          if (is_ins) begin
            count_q <= count_q + ids_pkg::CNT_W'(1);
            if (p_q == '0) begin
              front_q <= front_q - ids_pkg::IDX_W'(1);
            end
          end else begin
            count_q <= count_q - ids_pkg::CNT_W'(1);
            if (p_q == '0) begin
              front_q <= front_q + ids_pkg::IDX_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ids_pkg::OP_LOAD: begin
        item_q <= in_word_i;
      end
      ids_pkg::OP_PLAN: begin
        status_q <= plan_status;
        p_q      <= plan_p;
        taken_q  <= '1;
        down_q   <= is_ins;
        if (is_ins) begin
          src_q <= ids_pkg::IDX_W'(count_q - ids_pkg::CNT_W'(1));
          dst_q <= count_q[ids_pkg::IDX_W-1:0];
        end else begin
          src_q <= plan_p + ids_pkg::IDX_W'(1);
          dst_q <= plan_p;
        end
      end
      ids_pkg::OP_TAKE: begin
        taken_q <= rd_data_q;
      end
      ids_pkg::OP_SHIFT: begin
        if (left_q != '0) begin
          src_q <= down_q ? (src_q - ids_pkg::IDX_W'(1)) : (src_q + ids_pkg::IDX_W'(1));
        end
        if (inflight_q) begin
          dst_q <= down_q ? (dst_q - ids_pkg::IDX_W'(1)) : (dst_q + ids_pkg::IDX_W'(1));
        end
      end
      ids_pkg::OP_OUTPUT: begin
        out_q.taken_value <= 32'(signed'(taken_q));
        out_q.status      <= status_q;
        out_q.length      <= 7'(count_q);
      end
      default: begin
      end
    endcase
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire

[hw/rtl/ids_ctrl.sv]
`default_nettype none

module ids_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire ids_pkg::ids_stat_t stat_i,
  output ids_pkg::ids_cmd_t       cmd_o
);

  ids_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ids_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = ids_pkg::OP_NONE;
    in_ready_o  = (state_q == ids_pkg::S_IDLE);
    unique case (state_q)
      ids_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ids_pkg::OP_LOAD;
          state_d  = ids_pkg::S_DECODE;
        end
      end
      ids_pkg::S_DECODE: begin
        cmd_o.op = ids_pkg::OP_PLAN;
        if (stat_i.fail) begin
          state_d = ids_pkg::S_RESP;
        end else if (stat_i.is_remove) begin
          state_d = ids_pkg::S_READ;
        end else if (stat_i.has_copies) begin
          state_d = ids_pkg::S_SHIFT;
        end else begin
          state_d = ids_pkg::S_FINISH;
        end
      end
      ids_pkg::S_READ: begin
        cmd_o.op = ids_pkg::OP_READ;
        state_d  = ids_pkg::S_TAKE;
      end
      ids_pkg::S_TAKE: begin
        cmd_o.op = ids_pkg::OP_TAKE;
        state_d  = stat_i.has_copies ? ids_pkg::S_SHIFT : ids_pkg::S_FINISH;
      end
      ids_pkg::S_SHIFT: begin
        if (stat_i.shift_busy) begin
          cmd_o.op = ids_pkg::OP_SHIFT;
        end else begin
          state_d = ids_pkg::S_FINISH;
        end
      end
      ids_pkg::S_FINISH: begin
        cmd_o.op = ids_pkg::OP_FINISH;
        state_d  = ids_pkg::S_RESP;
      end
      ids_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = ids_pkg::OP_OUTPUT;
          out_valid_d = 1'b1;
          state_d     = ids_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ids_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/indexed_deque_store.sv]
// accept to result valid: decode, target read (pops, deletes), shift loop if values
// move, commit, output (held by an output stall); refused words skip to the output
// throughput: one word at a time, next word taken the cycle after the result registers
// the shift loop moves one value per cycle through the dual-port value memory
// reset (async, active low) empties the store: front slot and count cleared,
// memory contents are left as they are and never read before being written
`default_nettype none

`include "indexed_deque_store_macros.svh"

module indexed_deque_store (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ids_pkg::ids_in_t  in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ids_pkg::ids_out_t      out_word_o
);

  // command from sequencer to datapath, status flags back
  ids_pkg::ids_cmd_t  dp_cmd;
  ids_pkg::ids_stat_t dp_stat;

  // sequencer: decode, optional target read, shift loop, commit, output hand-off
  ids_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // datapath: value memory, front pointer, count, shift pointers, result register
  ids_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .in_word_i  (in_word_i),
    .stat_o     (dp_stat),
    .out_word_o (out_word_o)
  );

  // reported length never exceeds the store size
  `IDS_NEVER(a_len_bound, clk_i, rst_ni, out_valid_o && (out_word_o.length > 7'(ids_pkg::CAPACITY)))

  // any refused or failed command reports no taken value
  `IDS_ASSERT(a_fail_no_value, clk_i, rst_ni,
              out_valid_o && (out_word_o.status != ids_pkg::STAT_OK) |->
              out_word_o.taken_value == -32'sd1)

  // one word in flight: ready drops right after a word is taken
  `IDS_ASSERT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

  // no new word while values are still being moved
  `IDS_NEVER(a_ready_while_shift, clk_i, rst_ni, in_ready_o && dp_stat.shift_busy)

endmodule

`default_nettype wire
